// ===== hw/rtl/iclf_pkg.sv =====
package iclf_pkg;

  localparam int unsigned IdxW = 4;
  localparam int unsigned RgbW = 24;
  localparam int unsigned PalDepth = 16;

  typedef enum logic [2:0] {
    ReqSet   = 3'd0,
    ReqGet   = 3'd1,
    ReqAdd   = 3'd2,
    ReqClear = 3'd3,
    ReqReset = 3'd4,
    ReqShow  = 3'd5
  } req_e;

  localparam logic CfgWidth = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
    logic [RgbW-1:0] rgb;
    logic [3:0]      row;
    logic [7:0]      col;
    logic            show;
    logic            last;
  } res_t;

endpackage

// ===== hw/rtl/iclf_palette.sv =====
module iclf_palette (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [iclf_pkg::IdxW-1:0]  waddr_i,
  input  logic [iclf_pkg::RgbW-1:0]  wdata_i,
  input  logic [iclf_pkg::IdxW-1:0]  raddr_i,
  output logic [iclf_pkg::RgbW-1:0]  rdata_o
);

  logic [iclf_pkg::RgbW-1:0] mem_q [iclf_pkg::PalDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/iclf_pixels.sv =====
module iclf_pixels #(
  parameter int unsigned Depth = 512,
  parameter int unsigned AddrW = 9
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [iclf_pkg::IdxW-1:0] wdata_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [iclf_pkg::IdxW-1:0] rdata_o
);

  logic [iclf_pkg::IdxW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/indexed_colour_led_framebuffer.sv =====
// Palette-indexed LED framebuffer. One request at a time, busy high while it runs.
// Set writes the pixel memory without going busy; get reads it while busy, and its
// result appears as busy drops. Add colour walks the palette one entry per cycle,
// with the result in the cycle after. Show column emits one row per cycle through
// the pixel and palette memories, busy while rows remain in the read stages. Clear
// and reset sweep the pixel memory one entry per cycle; the same sweep runs after
// reset, also setting palette entry 0 to black, before the first request is taken.
// Results appear for one cycle with strobe_o and cannot be stalled.
module indexed_colour_led_framebuffer #(
  parameter int unsigned MAX_WIDTH = 32,
  parameter int unsigned MAX_HEIGHT = 16,
  parameter int unsigned PALETTE_MAX = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [5:0] cfg_data_i,
  input  logic [2:0] req_type_i,
  input  logic [7:0] col_x_i,
  input  logic [7:0] row_y_i,
  input  logic [3:0] pixel_index_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  output logic       strobe_o,
  output logic [3:0] index_out_o,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic [3:0] led_row_o,
  output logic [3:0] string_address_o,
  output logic       bank_high_o,
  output logic       last_item_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PalLim = (PALETTE_MAX < 15) ? PALETTE_MAX : 15;
  localparam logic [3:0] PalMax = 4'(PalLim);
  localparam logic [5:0] MaxW = 6'(MAX_WIDTH);
  localparam logic [6:0] MaxH = 7'(MAX_HEIGHT);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SSweep = 3'd1;
  localparam logic [2:0] SGet = 3'd2;
  localparam logic [2:0] SAdd = 3'd3;
  localparam logic [2:0] SShow = 3'd4;

  logic [2:0] state_q, state_d;
  logic [5:0] width_q;
  logic [4:0] height_q;
  logic [3:0] count_q, count_d;
  logic [AddrW:0] ptr_q, ptr_d;
  logic [4:0] step_q, step_d;
  logic [7:0] col_q, col_d;
  logic [23:0] rgb_q, rgb_d;
  logic inr_q, inr_d;
  logic [4:0] nrows_q, nrows_d;

  logic [5:0] eff_w;
  logic [6:0] eff_h;
  always_comb begin
    eff_w = (width_q < MaxW) ? width_q : MaxW;
    eff_h = ({2'b0, height_q} < MaxH) ? {2'b0, height_q} : MaxH;
  end

  logic pix_we;
  logic [AddrW-1:0] pix_waddr, pix_raddr;
  logic [3:0] pix_wdata, pix_rdata;
  logic pal_we;
  logic [3:0] pal_waddr, pal_raddr;
  logic [23:0] pal_wdata, pal_rdata;

  iclf_pixels #(.Depth(Depth), .AddrW(AddrW)) u_pixels (
    .clk_i, .we_i(pix_we), .waddr_i(pix_waddr), .wdata_i(pix_wdata),
    .raddr_i(pix_raddr), .rdata_o(pix_rdata)
  );

  iclf_palette u_palette (
    .clk_i, .we_i(pal_we), .waddr_i(pal_waddr), .wdata_i(pal_wdata),
    .raddr_i(pal_raddr), .rdata_o(pal_rdata)
  );

  // show pipeline: pixel read -> palette read -> output
  iclf_pkg::res_t s1_q, s1_d, s2_q, s2_d, out_q, out_d;

  logic accept;
  logic [AddrW-1:0] req_addr;
  logic req_inr;
  always_comb begin
    accept = start && !busy;
    req_inr = ({8'b0, col_x_i} < {10'b0, eff_w}) && ({8'b0, row_y_i} < {9'b0, eff_h});
    req_addr = AddrW'(32'(col_x_i) * MAX_HEIGHT + 32'(row_y_i));
  end

  // busy until the show pipeline has drained
  assign busy = (state_q != SIdle) || s1_q.valid || s2_q.valid;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ptr_d = ptr_q;
    step_d = step_q;
    col_d = col_q;
    rgb_d = rgb_q;
    inr_d = inr_q;
    nrows_d = nrows_q;
    pix_we = 1'b0;
    pix_waddr = ptr_q[AddrW-1:0];
    pix_wdata = '0;
    pix_raddr = req_addr;
    pal_we = 1'b0;
    pal_waddr = '0;
    pal_wdata = '0;
    pal_raddr = step_q[3:0];
    s1_d = '0;
    out_d = '0;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          col_d = col_x_i;
          rgb_d = {red_in_i, green_in_i, blue_in_i};
          inr_d = req_inr;
          priority case (req_type_i)
            iclf_pkg::ReqSet: begin
              pix_we = req_inr;
              pix_waddr = req_addr;
              pix_wdata = pixel_index_i;
            end
            iclf_pkg::ReqGet: state_d = SGet;
            iclf_pkg::ReqAdd: begin
              step_d = '0;
              pal_raddr = '0;
              state_d = SAdd;
            end
            iclf_pkg::ReqClear: begin
              ptr_d = '0;
              state_d = SSweep;
            end
            iclf_pkg::ReqReset: begin
              ptr_d = '0;
              count_d = '0;
              pal_we = 1'b1;
              state_d = SSweep;
            end
            iclf_pkg::ReqShow: begin
              if ({2'b0, col_x_i} < {4'b0, eff_w} && eff_h != '0) begin
                step_d = '0;
                nrows_d = (eff_h > 7'd16) ? 5'd16 : eff_h[4:0];
                state_d = SShow;
              end
            end
            default: ;
          endcase
        end
      end
      SSweep: begin
        pix_we = 1'b1;
        // entry 0 is always black
        pal_we = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == (AddrW+1)'(Depth - 1)) state_d = SIdle;
      end
      SGet: begin
        out_d.valid = 1'b1;
        out_d.idx = inr_q ? pix_rdata : '0;
        out_d.last = 1'b1;
        state_d = SIdle;
      end
      SAdd: begin
        // pal_rdata holds entry step_q
        if (pal_rdata == rgb_q) begin
          out_d.valid = 1'b1;
          out_d.idx = step_q[3:0];
          out_d.last = 1'b1;
          state_d = SIdle;
        end else if (step_q[3:0] == count_q) begin
          out_d.valid = 1'b1;
          out_d.last = 1'b1;
          if (count_q < PalMax) begin
            count_d = count_q + 1'b1;
            pal_we = 1'b1;
            pal_waddr = count_q + 1'b1;
            pal_wdata = rgb_q;
            out_d.idx = count_q + 1'b1;
          end else begin
            out_d.idx = count_q;
          end
          state_d = SIdle;
        end else begin
          step_d = step_q + 1'b1;
          pal_raddr = step_q[3:0] + 1'b1;
        end
      end
      SShow: begin
        pix_raddr = AddrW'(32'(col_q) * MAX_HEIGHT + 32'(step_q));
        s1_d.valid = 1'b1;
        s1_d.row = step_q[3:0];
        s1_d.col = col_q;
        s1_d.show = 1'b1;
        s1_d.last = (step_q + 1'b1 == nrows_q);
        step_d = step_q + 1'b1;
        if (s1_d.last) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    s2_d = s1_q;
    if (s1_q.valid) begin
      pal_raddr = pix_rdata;
      s2_d.idx = pix_rdata;
    end
    if (s2_q.valid) begin
      out_d = s2_q;
      out_d.rgb = pal_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SSweep;
      width_q <= 6'd32;
      height_q <= 5'd16;
      count_q <= '0;
      ptr_q <= '0;
      step_q <= '0;
      nrows_q <= '0;
      s1_q <= '0;
      s2_q <= '0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q <= ptr_d;
      step_q <= step_d;
      nrows_q <= nrows_d;
      s1_q <= s1_d;
      s2_q <= s2_d;
      out_q <= out_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == iclf_pkg::CfgWidth) width_q <= cfg_data_i;
        else height_q <= cfg_data_i[4:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
    rgb_q <= rgb_d;
    inr_q <= inr_d;
  end

  assign strobe_o = out_q.valid;
  assign index_out_o = out_q.idx;
  assign red_out_o = out_q.rgb[23:16];
  assign green_out_o = out_q.rgb[15:8];
  assign blue_out_o = out_q.rgb[7:0];
  assign led_row_o = out_q.row;
  assign string_address_o = out_q.show ? out_q.col[3:0] : 4'd0;
  assign bank_high_o = out_q.show && (out_q.col >= 8'd16);
  assign last_item_o = out_q.last;

endmodule

// ===== hw/rtl/iclf_checker.sv =====
module iclf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic strobe_o,
  input logic last_item_o,
  input logic bank_high_o,
  input logic [3:0] led_row_o
);

  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_item_o) |-> busy) else $error("idle during show");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_item_o) |=> !strobe_o) else $error("result after last");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_item_o) |=> strobe_o && (led_row_o == $past(led_row_o) + 4'd1))
    else $error("row sequence");

  a_bank_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_item_o) |=> $stable(bank_high_o)) else $error("bank changed");

endmodule

bind indexed_colour_led_framebuffer iclf_checker u_iclf_checker (
  .clk_i, .rst_ni, .start, .busy, .strobe_o, .last_item_o, .bank_high_o, .led_row_o
);
